// ===== rtl/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: sector codes, stage payload types
// and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h1_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Color wheel sector, hue * 6 integer part.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  // Output of the front stages: the three Q.32 factors that scale v.
  typedef struct packed {
    sector_e     sector;
    logic [16:0] v;
    logic [32:0] kp;
    logic [32:0] kq;
    logic [32:0] kt;
  } coef_t;

  // Output of the multiply stage: p, q and t in Q.48.
  typedef struct packed {
    sector_e     sector;
    logic [16:0] v;
    logic [48:0] xp;
    logic [48:0] xq;
    logic [48:0] xt;
  } prod_t;

  // Clamp a Q1.16 value to 1.0.
  function automatic logic [16:0] sat_one(input logic [16:0] x);
    return (x > ONE_Q16) ? ONE_Q16 : x;
  endfunction

  // floor(x * 255 / 2^48) for x at most 2^48.
  function automatic logic [7:0] chan48(input logic [48:0] x);
    logic [56:0] m;
    m = {x, 8'b0} - 57'(x);
    return m[55:48];
  endfunction

  // floor(v * 255 / 2^16) for v at most 2^16.
  function automatic logic [7:0] chan16(input logic [16:0] v);
    logic [24:0] m;
    m = {v, 8'b0} - 25'(v);
    return m[23:16];
  endfunction

endpackage

// ===== rtl/hsv2rgb_front.sv =====
// Front stages of the HSV to RGB converter: clamp, sector split, then the
// p, q and t scale factors. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  output logic                rdy_o,
  input  logic [15:0]         hue_i,
  input  logic [16:0]         sat_i,
  input  logic [16:0]         val_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output hsv2rgb_pkg::coef_t  coef_o
);

  logic                 a_vld_q;
  hsv2rgb_pkg::sector_e a_sec_q;
  logic [15:0]          a_f_q;
  logic [16:0]          a_s_q, a_v_q;
  logic                 b_vld_q;
  hsv2rgb_pkg::coef_t   b_coef_q, b_coef_d;
  logic                 rdy_a, rdy_b;
  logic [18:0]          h6;
  logic [32:0]          sf;

  assign rdy_b = !b_vld_q || rdy_i;
  assign rdy_a = !a_vld_q || rdy_b;
  assign rdy_o = rdy_a;

  assign h6 = {3'b0, hue_i} * 19'd6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (rdy_a) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && vld_i) begin
      a_sec_q <= hsv2rgb_pkg::sector_e'(h6[18:16]);
      a_f_q   <= h6[15:0];
      a_s_q   <= hsv2rgb_pkg::sat_one(sat_i);
      a_v_q   <= hsv2rgb_pkg::sat_one(val_i);
    end
  end

  // s*(1-f) is formed as s*2^16 - s*f so one multiplier serves both factors.
  assign sf = 33'(a_s_q) * 33'(a_f_q);

  always_comb begin
    b_coef_d.sector = a_sec_q;
    b_coef_d.v      = a_v_q;
    b_coef_d.kp     = {hsv2rgb_pkg::ONE_Q16 - a_s_q, 16'b0};
    b_coef_d.kq     = hsv2rgb_pkg::ONE_Q32 - sf;
    b_coef_d.kt     = hsv2rgb_pkg::ONE_Q32 - {a_s_q, 16'b0} + sf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (rdy_b) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && a_vld_q) begin
      b_coef_q <= b_coef_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign coef_o = b_coef_q;

endmodule

// ===== rtl/hsv2rgb_mul.sv =====
// Multiply stage of the HSV to RGB converter: v times each scale factor,
// three parallel 17 by 33 bit products. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  output logic                rdy_o,
  input  hsv2rgb_pkg::coef_t  coef_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output hsv2rgb_pkg::prod_t  prod_o
);

  logic               vld_q;
  hsv2rgb_pkg::prod_t prod_q, prod_d;

  assign rdy_o = !vld_q || rdy_i;

  always_comb begin
    prod_d.sector = coef_i.sector;
    prod_d.v      = coef_i.v;
    prod_d.xp     = 49'(coef_i.v) * 49'(coef_i.kp);
    prod_d.xq     = 49'(coef_i.v) * 49'(coef_i.kq);
    prod_d.xt     = 49'(coef_i.v) * 49'(coef_i.kt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      prod_q <= prod_d;
    end
  end

  assign vld_o  = vld_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/hsv2rgb_out.sv =====
// Output stage of the HSV to RGB converter: scale to 8 bits, pick the
// sector permutation and hold the result register. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  output logic                rdy_o,
  input  hsv2rgb_pkg::prod_t  prod_i,
  output logic                vld_o,
  input  logic                stall_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);

  logic       vld_q;
  logic [7:0] red_q, green_q, blue_q;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] cv, cp, cq, ct;

  assign rdy_o = !vld_q || !stall_i;

  assign cv = hsv2rgb_pkg::chan16(prod_i.v);
  assign cp = hsv2rgb_pkg::chan48(prod_i.xp);
  assign cq = hsv2rgb_pkg::chan48(prod_i.xq);
  assign ct = hsv2rgb_pkg::chan48(prod_i.xt);

  always_comb begin
    case (prod_i.sector)
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        red_d = cq; green_d = cv; blue_d = cp;
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        red_d = cp; green_d = cv; blue_d = ct;
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        red_d = cp; green_d = cq; blue_d = cv;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        red_d = ct; green_d = cp; blue_d = cv;
      end
      hsv2rgb_pkg::SEC_MAGENTA_RED: begin
        red_d = cv; green_d = cp; blue_d = cq;
      end
      default: begin
        red_d = cv; green_d = ct; blue_d = cp;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign vld_o   = vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// Top level of the HSV to RGB converter pipeline.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_mul and hsv2rgb_out.
`timescale 1ns / 1ps

// Usage
// The input channel carries one pixel per transfer: hue in Q0.16 of a full
// turn, saturation and brightness in Q1.16 (values above 1.0 are clamped).
// The output channel carries one 8-bit red, green, blue triple per transfer.
// Both channels move a transfer on a rising edge where valid is high and
// stall is low.
// Each pixel passes through four stages in order into the output register;
// while the input is not stalled, one pixel is taken every cycle. The
// stages are the clamp and hue * 6 sector split, the s * f multiply for the
// scale factors, the three 17 by 33 bit products of v, and the scaling to 8
// bits with the sector permutation into the output register.
// When the receiver stalls, the result stays on the output unchanged and the
// stages behind it keep filling; empty stages absorb new pixels, so the input
// only stalls once every stage holds a pixel.
// Reset clears all valid bits; nothing else carries state from pixel to pixel.
// Black and gray need no special handling: with zero brightness every
// product is zero, and with zero saturation p, q and t all equal v.

module hsv_to_rgb_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] hue_i,
  input  logic [16:0] saturation_i,
  input  logic [16:0] brightness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  logic               front_rdy;
  logic               coef_vld, coef_rdy;
  logic               prod_vld, prod_rdy;
  hsv2rgb_pkg::coef_t coef;
  hsv2rgb_pkg::prod_t prod;

  // Stages one and two: clamp, sector split and scale factors.
  hsv2rgb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_valid_i),
    .rdy_o  (front_rdy),
    .hue_i  (hue_i),
    .sat_i  (saturation_i),
    .val_i  (brightness_i),
    .vld_o  (coef_vld),
    .rdy_i  (coef_rdy),
    .coef_o (coef)
  );

  // Stage three: v times the factors.
  hsv2rgb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (coef_vld),
    .rdy_o  (coef_rdy),
    .coef_i (coef),
    .vld_o  (prod_vld),
    .rdy_i  (prod_rdy),
    .prod_o (prod)
  );

  // Stage four: 8-bit scaling, permutation and the output register.
  hsv2rgb_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (prod_vld),
    .rdy_o   (prod_rdy),
    .prod_i  (prod),
    .vld_o   (out_valid_o),
    .stall_i (out_stall_i),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  assign in_stall_o = !front_rdy;

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter and its bind statement.
// Depends only on the ports of hsv_to_rgb_converter_top.
`timescale 1ns / 1ps

module hsv2rgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [15:0] hue_i,
  input logic [16:0] saturation_i,
  input logic [16:0] brightness_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o
);

  // Nothing is presented while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

  // A stalled pixel on the input stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(hue_i) && $stable(saturation_i) &&
      $stable(brightness_i))
    else $error("stalled input pixel changed");

  // Back pressure only comes from a stalled, full output.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // An empty output register means the whole pipeline can take a pixel.
  a_empty_ready: assert property (@(posedge clk_i)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_hsv2rgb_checker (.*);
